// File: src/byte_run_length_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// byte_run_length_decoder_core_defines
// Assertion macros used by the run-length decoder core.
// ----------------------------------------------------------------------------
`ifndef BYTE_RUN_LENGTH_DECODER_CORE_DEFINES_SVH
`define BYTE_RUN_LENGTH_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BRLD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brld assertion failed");

// next-cycle implication, checked outside reset
`define BRLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brld assertion failed");

`endif

// File: src/brld_pkg.sv
// ----------------------------------------------------------------------------
// brld_pkg
// Widths, codes and shared types of the byte run-length decoder.
// ----------------------------------------------------------------------------
package brld_pkg;

    // field and counter widths
    localparam int COUNT_BITS  = 24;
    localparam int CFG_BITS    = 24;
    localparam int ACC_BITS    = 32;
    localparam int LEN_BITS    = 25;
    localparam int STATUS_BITS = 3;

    // varint byte fields
    localparam logic [7:0] VARINT_CONT = 8'h80;
    localparam logic [7:0] VARINT_DATA = 8'h7F;

    // header codes
    localparam logic [7:0] HDR_RAW    = 8'd0;
    localparam logic [7:0] HDR_PAIR   = 8'd1;
    localparam logic [7:0] HDR_TWOVAL = 8'd2;
    localparam logic [7:0] HDR_ABSENT = 8'd3;

    // mode codes
    localparam logic [1:0] MODE_RAW    = 2'd0;
    localparam logic [1:0] MODE_PAIR   = 2'd1;
    localparam logic [1:0] MODE_TWOVAL = 2'd2;
    localparam logic [1:0] MODE_ABSENT = 2'd3;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_RUN     = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_OVERRUN = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_DONE0   = 3'd4;

    // one decoded result
    typedef struct packed {
        logic                   valid;
        logic [STATUS_BITS-1:0] status;
        logic [7:0]             value;
        logic [LEN_BITS-1:0]    length;
        logic                   last;
    } t_result;

    // input stage to decoder
    typedef struct packed {
        logic       step;
        logic [7:0] data;
    } t_byte_slot;

endpackage

// File: src/brld_in_stage.sv
// ----------------------------------------------------------------------------
// brld_in_stage
// Input register of the decoder; holds one stream byte until it is decoded.
// ----------------------------------------------------------------------------
module brld_in_stage
    import brld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_stream_byte,
    input  logic       i_out_free,
    output t_byte_slot o_slot
);

    logic       r_valid;
    logic [7:0] r_byte;

    // the held byte moves on whenever the result side has room
    assign o_in_stall  = r_valid && !i_out_free;
    assign o_slot.step = r_valid && i_out_free;
    assign o_slot.data = r_byte;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    // byte register
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_stream_byte;
        end
    end

endmodule

// File: src/brld_decode.sv
// ----------------------------------------------------------------------------
// brld_decode
// Decoder state and the single-pass step logic for one stream byte.
// ----------------------------------------------------------------------------
module brld_decode
    import brld_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_byte_slot          i_slot,
    input  logic [CFG_BITS-1:0] i_element_count,
    output t_result             o_result
);

    // phase codes
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_RAW    = 3'd1;
    localparam logic [2:0] PH_VALUE  = 3'd2;
    localparam logic [2:0] PH_VAL0   = 3'd3;
    localparam logic [2:0] PH_VAL1   = 3'd4;
    localparam logic [2:0] PH_LEN    = 3'd5;

    logic [2:0]            r_phase, n_phase;
    logic [1:0]            r_mode, n_mode;
    logic [ACC_BITS-1:0]   r_acc, n_acc;
    logic [COUNT_BITS-1:0] r_remaining, n_remaining;
    logic [7:0]            r_pending, n_pending;
    logic                  r_alt, n_alt;
    logic [7:0]            r_pair [2];

    logic                  pair_we0, pair_we1;
    logic                  do_run;
    logic [ACC_BITS-1:0]   run_n;
    logic [7:0]            run_val;
    logic [ACC_BITS:0]     run_diff;
    logic [7:0]            b;

    assign b = i_slot.data;

    // next state and result for the byte in the input register
    always_comb begin
        n_phase     = r_phase;
        n_mode      = r_mode;
        n_acc       = r_acc;
        n_remaining = r_remaining;
        n_pending   = r_pending;
        n_alt       = r_alt;
        pair_we0    = 1'b0;
        pair_we1    = 1'b0;
        do_run      = 1'b0;
        run_n       = '0;
        run_val     = b;
        run_diff    = '0;
        o_result    = '0;

        unique case (r_phase)
            PH_HEADER: begin
                n_acc       = '0;
                n_alt       = 1'b0;
                n_remaining = COUNT_BITS'(i_element_count);
                if (b > HDR_ABSENT) begin
                    o_result = '{valid: 1'b1, status: ST_UNKNOWN, value: 8'd0,
                                 length: '0, last: 1'b1};
                end else begin
                    n_mode = b[1:0];
                    if (b == HDR_ABSENT) begin
                        o_result = '{valid: 1'b1, status: ST_ABSENT, value: 8'd0,
                                     length: '0, last: 1'b1};
                    end else if (b == HDR_TWOVAL) begin
                        n_phase = PH_VAL0;
                    end else if (i_element_count == '0) begin
                        o_result = '{valid: 1'b1, status: ST_DONE0, value: 8'd0,
                                     length: '0, last: 1'b1};
                    end else begin
                        n_phase = (b == HDR_RAW) ? PH_RAW : PH_VALUE;
                    end
                end
            end
            PH_RAW: begin
                do_run  = 1'b1;
                run_n   = '0;
                run_val = b;
            end
            PH_VALUE: begin
                n_pending = b;
                n_acc     = '0;
                n_phase   = PH_LEN;
            end
            PH_VAL0: begin
                pair_we0 = 1'b1;
                n_phase  = PH_VAL1;
            end
            PH_VAL1: begin
                pair_we1 = 1'b1;
                n_acc    = '0;
                if (r_remaining == '0) begin
                    n_phase  = PH_HEADER;
                    o_result = '{valid: 1'b1, status: ST_DONE0, value: 8'd0,
                                 length: '0, last: 1'b1};
                end else begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if ((b & VARINT_CONT) != 8'd0) begin
                    // continuation byte: shift seven more bits in
                    n_acc = {r_acc[ACC_BITS-8:0], b[6:0]};
                end else begin
                    n_acc  = '0;
                    do_run = 1'b1;
                    run_n  = {r_acc[ACC_BITS-8:0], b[6:0]};
                    if (r_mode == MODE_TWOVAL) begin
                        run_val = r_pair[r_alt];
                        n_alt   = !r_alt;
                    end else begin
                        run_val = r_pending;
                        n_phase = PH_VALUE;
                    end
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        // run check: remaining - (n + 1), negative means overrun
        if (do_run) begin
            run_diff = (ACC_BITS+1)'(r_remaining) - {1'b0, run_n} - 1'b1;
            if (run_diff[ACC_BITS]) begin
                n_phase  = PH_HEADER;
                o_result = '{valid: 1'b1, status: ST_OVERRUN, value: run_val,
                             length: '0, last: 1'b1};
            end else begin
                n_remaining = run_diff[COUNT_BITS-1:0];
                o_result = '{valid: 1'b1, status: ST_RUN, value: run_val,
                             length: LEN_BITS'({1'b0, run_n} + 1'b1),
                             last: (run_diff[COUNT_BITS-1:0] == '0)};
                if (run_diff[COUNT_BITS-1:0] == '0) begin
                    n_phase = PH_HEADER;
                end
            end
        end

        if (!i_slot.step) begin
            o_result.valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_mode      <= MODE_RAW;
            r_acc       <= '0;
            r_remaining <= '0;
            r_pending   <= 8'd0;
            r_alt       <= 1'b0;
        end else if (i_slot.step) begin
            r_phase     <= n_phase;
            r_mode      <= n_mode;
            r_acc       <= n_acc;
            r_remaining <= n_remaining;
            r_pending   <= n_pending;
            r_alt       <= n_alt;
        end
    end

    // the two values of two-value mode
    always_ff @(posedge i_clk) begin
        if (i_slot.step && pair_we0) begin
            r_pair[0] <= b;
        end
        if (i_slot.step && pair_we1) begin
            r_pair[1] <= b;
        end
    end

endmodule

// File: src/byte_run_length_decoder_core.sv
// ----------------------------------------------------------------------------
// byte_run_length_decoder_core
// Decodes a byte stream of run-length headers, values and varint lengths
// into run descriptors, one stream byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  in       | to core   | i_in_valid / o_in_stall  | i_stream_byte
//  out      | from core | o_out_valid / i_out_stall| o_status, o_run_value,
//           |           |                          | o_run_length, o_last
//  cfg      | to core   | i_cfg_valid / o_cfg_ready| i_cfg_data (element count)
//
//  One stream byte per cycle while the output is not stalled; a byte passes
//  the input register and its result is held in the result register until taken.
//  The decode step is a single add/compare on the remaining count per byte.
//  Synchronous active-low reset; the element count resets to zero.
//  A stall on the output holds both the result register and the input register.
// ----------------------------------------------------------------------------
`include "byte_run_length_decoder_core_defines.svh"

module byte_run_length_decoder_core
    import brld_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // stream byte transfer
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_stream_byte,
    // result transfer
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [7:0]             o_run_value,
    output logic [LEN_BITS-1:0]    o_run_length,
    output logic                   o_last,
    // configuration write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_BITS-1:0]    i_cfg_data
);

    logic [CFG_BITS-1:0] r_element_count;
    logic                r_out_valid;
    t_result             r_out;
    t_result             step_result;
    t_byte_slot          slot;
    logic                out_free;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // element count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_element_count <= i_cfg_data;
        end
    end

    // input register
    brld_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_stream_byte (i_stream_byte),
        .i_out_free    (out_free),
        .o_slot        (slot)
    );

    // decode step and state
    brld_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slot          (slot),
        .i_element_count (r_element_count),
        .o_result        (step_result)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step_result.valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (out_free && step_result.valid) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_run_value  = r_out.value;
    assign o_run_length = r_out.length;
    assign o_last       = r_out.last;

    // error and end reports always close the set
    `BRLD_ASSERT_NOW(a_non_run_last, i_clk, i_rst_n, o_out_valid && o_status != ST_RUN, o_last)
    // a run result always covers at least one element
    `BRLD_ASSERT_NOW(a_run_nonzero, i_clk, i_rst_n, o_out_valid && o_status == ST_RUN, o_run_length != '0)
    // non-run results carry no length
    `BRLD_ASSERT_NOW(a_non_run_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_RUN, o_run_length == '0)
    // input only stalls behind a held result
    `BRLD_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

endmodule
